// ===== sv/cdo_pkg.sv =====
// Package for the calendar date offset unit: field widths, year limits and
// the month length table with the Gregorian leap rule. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdo_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int OFS_W   = 17;
  localparam int M400_W  = 9;

  localparam int MAX_OFFSET_DEF = 65535;
  // Largest magnitude that a 17-bit two's complement offset can carry.
  localparam int OFS_MAG_MAX = 65536;

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  YEAR_CYCLE = YEAR_W'(400);
  localparam logic [M400_W-1:0]  M400_LAST  = M400_W'(399);
  localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_DEC_END = DAY_W'(31);

  // Leap year from the year taken modulo 400.
  function automatic logic is_leap(input logic [M400_W-1:0] m400);
    logic century;
    century = (m400 == M400_W'(100)) || (m400 == M400_W'(200)) ||
              (m400 == M400_W'(300));
    return (m400[1:0] == 2'd0) && !century;
  endfunction

  // Days in a month (1..12); codes outside that range never reach here.
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9,
      4'd11:               len = DAY_W'(30);
      default:             len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cdo_step.sv =====
// One-day step unit of the calendar date offset unit: moves a date one day
// forward or back and flags the year range limits. Depends on cdo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdo_step
  import cdo_pkg::*;
(
  input  wire logic [DAY_W-1:0]   day,
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [YEAR_W-1:0]  year,
  input  wire logic [M400_W-1:0]  m400,
  input  wire logic               back,
  output logic      [DAY_W-1:0]   next_day,
  output logic      [MONTH_W-1:0] next_month,
  output logic      [YEAR_W-1:0]  next_year,
  output logic      [M400_W-1:0]  next_m400,
  output logic                    at_limit
);

  logic leap;
  logic [MONTH_W-1:0] month_prev;

  assign leap       = is_leap(m400);
  assign month_prev = month - MONTH_W'(1);

  always_comb begin
    next_day   = day;
    next_month = month;
    next_year  = year;
    next_m400  = m400;
    at_limit   = 1'b0;
    if (!back) begin
      if (day < days_in(month, leap)) begin
        next_day = day + DAY_W'(1);
      end else if (month < MONTH_DEC) begin
        next_day   = DAY_FIRST;
        next_month = month + MONTH_W'(1);
      end else if (year < YEAR_MAX) begin
        next_day   = DAY_FIRST;
        next_month = MONTH_JAN;
        next_year  = year + YEAR_W'(1);
        next_m400  = (m400 == M400_LAST) ? '0 : m400 + M400_W'(1);
      end else begin
        at_limit = 1'b1;
      end
    end else begin
      if (day > DAY_FIRST) begin
        next_day = day - DAY_W'(1);
      end else if (month > MONTH_JAN) begin
        next_month = month_prev;
        next_day   = days_in(month_prev, leap);
      end else if (year != '0) begin
        next_year  = year - YEAR_W'(1);
        next_month = MONTH_DEC;
        next_day   = DAY_DEC_END;
        next_m400  = (m400 == '0) ? M400_LAST : m400 - M400_W'(1);
      end else begin
        at_limit = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/calendar_date_offset_unit.sv =====
// Top level of the calendar date offset unit: sequencer, date registers and
// output register around the single one-day step unit. Depends on cdo_pkg, cdo_step.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   input   | in_valid, in_stall, in_day, in_month, in_year, | in
//           | day_offset                                    |
//   result  | out_valid, out_stall, out_day, out_month,      | out
//           | out_year, range_error                         |
//
// An accepted item runs R = floor(year / 400) subtractions (at most 24) that find
// the year modulo 400, then N = min(|offset|, MAX_OFFSET) passes of the one-day
// step unit, fewer if the year range limit is hit, before its result word is
// loaded; the input takes a new word in the cycle after that.
// in_stall is high from acceptance until the result word is in the output
// register. A result word waiting under out_stall does not block the next
// input word, but the following result waits until the register is free.
// rst_n is synchronous and active low; it empties the unit and the output.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_offset_unit
  import cdo_pkg::*;
#(
  parameter int MAX_OFFSET = MAX_OFFSET_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [DAY_W-1:0]   in_day,
  input  wire logic [MONTH_W-1:0] in_month,
  input  wire logic [YEAR_W-1:0]  in_year,
  input  wire logic [OFS_W-1:0]   day_offset,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [DAY_W-1:0]   out_day,
  output logic      [MONTH_W-1:0] out_month,
  output logic      [YEAR_W-1:0]  out_year,
  output logic                    range_error
);

  localparam int LIM   = (MAX_OFFSET < OFS_MAG_MAX) ? MAX_OFFSET : OFS_MAG_MAX;
  localparam int CNT_W = $clog2(LIM + 1);
  localparam logic [CNT_W-1:0] LIM_CNT = CNT_W'(LIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CLAMP,
    ST_STEP
  } state_t;

  state_t state_r, state_nxt;

  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [YEAR_W-1:0]  rem_r, rem_nxt;
  logic               back_r, back_nxt;
  logic [OFS_W-1:0]   mag_r, mag_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [DAY_W-1:0]   out_day_r, out_day_nxt;
  logic [MONTH_W-1:0] out_month_r, out_month_nxt;
  logic [YEAR_W-1:0]  out_year_r, out_year_nxt;
  logic               range_error_r, range_error_nxt;

  logic [DAY_W-1:0]   st_day;
  logic [MONTH_W-1:0] st_month;
  logic [YEAR_W-1:0]  st_year;
  logic [M400_W-1:0]  st_m400;
  logic               st_limit;
  logic [DAY_W-1:0]   dim;
  logic               in_acc;
  logic               out_free;

  cdo_step u_step (
    .day        (day_r),
    .month      (month_r),
    .year       (year_r),
    .m400       (rem_r[M400_W-1:0]),
    .back       (back_r),
    .next_day   (st_day),
    .next_month (st_month),
    .next_year  (st_year),
    .next_m400  (st_m400),
    .at_limit   (st_limit)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign dim      = days_in(month_r, is_leap(rem_r[M400_W-1:0]));

  always_comb begin
    state_nxt       = state_r;
    day_nxt         = day_r;
    month_nxt       = month_r;
    year_nxt        = year_r;
    rem_nxt         = rem_r;
    back_nxt        = back_r;
    mag_nxt         = mag_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_day_nxt     = out_day_r;
    out_month_nxt   = out_month_r;
    out_year_nxt    = out_year_r;
    range_error_nxt = range_error_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          day_nxt = in_day;
          if (in_month == '0) begin
            month_nxt = MONTH_JAN;
          end else if (in_month > MONTH_DEC) begin
            month_nxt = MONTH_DEC;
          end else begin
            month_nxt = in_month;
          end
          year_nxt  = (in_year > YEAR_MAX) ? YEAR_MAX : in_year;
          rem_nxt   = (in_year > YEAR_MAX) ? YEAR_MAX : in_year;
          back_nxt  = day_offset[OFS_W-1];
          mag_nxt   = day_offset[OFS_W-1] ? (~day_offset + OFS_W'(1)) : day_offset;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // Year modulo 400 by repeated subtraction; it then tracks the year.
        if (rem_r >= YEAR_CYCLE) begin
          rem_nxt = rem_r - YEAR_CYCLE;
        end else begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (day_r == '0) begin
          day_nxt = DAY_FIRST;
        end else if (day_r > dim) begin
          day_nxt = dim;
        end
        cnt_nxt   = ({15'd0, mag_r} > 32'(LIM)) ? LIM_CNT : CNT_W'(mag_r);
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (cnt_r == '0 || st_limit) begin
          if (out_free) begin
            out_valid_nxt   = 1'b1;
            out_day_nxt     = day_r;
            out_month_nxt   = month_r;
            out_year_nxt    = year_r;
            range_error_nxt = (cnt_r != '0);
            state_nxt       = ST_IDLE;
          end
        end else begin
          day_nxt   = st_day;
          month_nxt = st_month;
          year_nxt  = st_year;
          rem_nxt   = {{(YEAR_W-M400_W){1'b0}}, st_m400};
          cnt_nxt   = cnt_r - CNT_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    day_r         <= day_nxt;
    month_r       <= month_nxt;
    year_r        <= year_nxt;
    rem_r         <= rem_nxt;
    back_r        <= back_nxt;
    mag_r         <= mag_nxt;
    cnt_r         <= cnt_nxt;
    out_day_r     <= out_day_nxt;
    out_month_r   <= out_month_nxt;
    out_year_r    <= out_year_nxt;
    range_error_r <= range_error_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_day     = out_day_r;
  assign out_month   = out_month_r;
  assign out_year    = out_year_r;
  assign range_error = range_error_r;

  // The month is clamped on acceptance and stays legal while the item runs.
  a_month_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLAMP || state_r == ST_STEP) |-> (month_r >= MONTH_JAN && month_r <= MONTH_DEC))
    else $error("month register left 1..12 during an item");

  // While stepping, the day is always a legal day of its month.
  a_day_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (day_r >= DAY_FIRST && day_r <= dim))
    else $error("day register is not a legal day of its month");

  // The year never leaves the supported range while an item runs.
  a_year_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_REDUCE) |-> (year_r <= YEAR_MAX))
    else $error("year register above the supported range");

  // An accepted word always starts with the modulo reduction.
  a_accept_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_REDUCE))
    else $error("accepted word did not start the reduction");

  // A new result word only appears at the end of the stepping phase.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> ($past(state_r) == ST_STEP))
    else $error("result word loaded outside the stepping phase");

endmodule

`default_nettype wire

// ===== tb/sv/tb_calendar_date_offset_unit.sv =====
// Self-checking testbench for calendar_date_offset_unit: a predictor of date
// stepping feeds a scoreboard that checks each result word. Depends on cdo_pkg and calendar_date_offset_unit.
`timescale 1ns / 1ps

module tb_calendar_date_offset_unit;
  import cdo_pkg::*;

  localparam int OFFSET_LIMIT   = MAX_OFFSET_DEF;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_DATES   = 100;
  localparam int unsigned MONTH_LEN[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               err;
  } date_word_t;

  function automatic bit leap_year(input int unsigned y);
    if (y % 100 == 0) begin
      return (y % 400) == 0;
    end
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    if (m == MONTH_FEB && leap_year(y)) begin
      return 29;
    end
    return MONTH_LEN[m - 1];
  endfunction

  class date_scoreboard;
    date_word_t expected_dates[$];
    int errors;
    int n_checked;
    int n_saturated;

    task report(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // Steps the clamped start date one day at a time, as the unit does.
    function date_word_t add_days(input logic [DAY_W-1:0] d_in,
                                  input logic [MONTH_W-1:0] m_in,
                                  input logic [YEAR_W-1:0] y_in,
                                  input logic [OFS_W-1:0] ofs);
      int unsigned d;
      int unsigned m;
      int unsigned y;
      int unsigned steps;
      bit back;
      bit hit_limit;
      date_word_t r;
      m = (m_in < MONTH_JAN) ? MONTH_JAN : ((m_in > MONTH_DEC) ? MONTH_DEC : m_in);
      y = (y_in > YEAR_MAX) ? YEAR_MAX : y_in;
      d = (d_in < DAY_FIRST) ? DAY_FIRST : d_in;
      if (d > month_length(m, y)) begin
        d = month_length(m, y);
      end
      back = ofs[OFS_W-1];
      steps = back ? ((32'd1 << OFS_W) - 32'(ofs)) : 32'(ofs);
      if (steps > OFFSET_LIMIT) begin
        steps = OFFSET_LIMIT;
      end
      hit_limit = 1'b0;
      for (int unsigned i = 0; i < steps; i++) begin
        if (!back) begin
          if (d < month_length(m, y)) begin
            d++;
          end else if (m < MONTH_DEC) begin
            d = DAY_FIRST;
            m++;
          end else if (y < YEAR_MAX) begin
            d = DAY_FIRST;
            m = MONTH_JAN;
            y++;
          end else begin
            hit_limit = 1'b1;
          end
        end else begin
          if (d > DAY_FIRST) begin
            d--;
          end else if (m > MONTH_JAN) begin
            m--;
            d = month_length(m, y);
          end else if (y > 0) begin
            y--;
            m = MONTH_DEC;
            d = DAY_DEC_END;
          end else begin
            hit_limit = 1'b1;
          end
        end
        if (hit_limit) begin
          break;
        end
      end
      r.day   = DAY_W'(d);
      r.month = MONTH_W'(m);
      r.year  = YEAR_W'(y);
      r.err   = hit_limit;
      return r;
    endfunction

    function void note_start_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                                  input logic [YEAR_W-1:0] y, input logic [OFS_W-1:0] ofs);
      expected_dates.push_back(add_days(d, m, y, ofs));
    endfunction

    task check_result_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                           input logic [YEAR_W-1:0] y, input logic e);
      date_word_t want;
      if (expected_dates.size() == 0) begin
        report($sformatf("result word %0d/%0d/%0d arrived with nothing expected", d, m, y));
        return;
      end
      want = expected_dates.pop_front();
      n_checked++;
      if (want.err) begin
        n_saturated++;
      end
      if (d !== want.day) begin
        report($sformatf("out_day %0d, expected %0d", d, want.day));
      end
      if (m !== want.month) begin
        report($sformatf("out_month %0d, expected %0d", m, want.month));
      end
      if (y !== want.year) begin
        report($sformatf("out_year %0d, expected %0d", y, want.year));
      end
      if (e !== want.err) begin
        report($sformatf("range_error %0b, expected %0b", e, want.err));
      end
    endtask

    function int outstanding();
      return expected_dates.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [DAY_W-1:0]   in_day;
  logic [MONTH_W-1:0] in_month;
  logic [YEAR_W-1:0]  in_year;
  logic [OFS_W-1:0]   day_offset;
  logic               out_valid;
  logic               out_stall;
  logic [DAY_W-1:0]   out_day;
  logic [MONTH_W-1:0] out_month;
  logic [YEAR_W-1:0]  out_year;
  logic               range_error;

  date_scoreboard sb;
  int burst_left;
  int n_sent;
  int idle_cycles;
  int rx_phase;
  int rx_mode;

  calendar_date_offset_unit #(.MAX_OFFSET(OFFSET_LIMIT)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_day(in_day), .in_month(in_month), .in_year(in_year), .day_offset(day_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_day(out_day), .out_month(out_month), .out_year(out_year),
    .range_error(range_error)
  );

  always #4 clk = ~clk;

  // The receiver switches between no stalls, light stalls and heavy stalls.
  always @(negedge clk) begin
    if (rx_phase == 0) begin
      rx_mode <= $urandom_range(0, 2);
    end
    rx_phase <= (rx_phase == 49) ? 0 : rx_phase + 1;
    case (rx_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result_date(out_day, out_month, out_year, range_error);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without a word moving", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                           input logic [YEAR_W-1:0] y, input logic [OFS_W-1:0] ofs);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_day     <= d;
    in_month   <= m;
    in_year    <= y;
    day_offset <= ofs;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_start_date(d, m, y, ofs);
    n_sent++;
  endtask

  // Drops valid and scrambles the payload meanwhile; n sets how long the input stays idle.
  task automatic idle_input(input int n);
    @(negedge clk);
    in_valid   <= 1'b0;
    in_day     <= DAY_W'($urandom);
    in_month   <= MONTH_W'($urandom);
    in_year    <= YEAR_W'($urandom);
    day_offset <= OFS_W'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_paced(input int d, input int m, input int y, input int ofs);
    send_date(DAY_W'(d), MONTH_W'(m), YEAR_W'(y), OFS_W'(ofs));
    burst_left--;
    if (burst_left <= 0) begin
      idle_input($urandom_range(1, 5));
      burst_left = ($urandom_range(0, 4) == 0) ? 25 : $urandom_range(1, 6);
    end
  endtask

  task automatic send_random_date();
    int unsigned sel;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned yc;
    int unsigned mc;
    int unsigned mag;
    int ofs;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      y = $urandom_range(0, 9999);
    end else if (sel < 80) begin
      y = $urandom_range(0, 3);
    end else if (sel < 90) begin
      y = $urandom_range(9996, 9999);
    end else begin
      y = $urandom_range(0, (1 << YEAR_W) - 1);
    end
    m = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 15);
    yc = (y > YEAR_MAX) ? YEAR_MAX : y;
    mc = (m < MONTH_JAN) ? MONTH_JAN : ((m > MONTH_DEC) ? MONTH_DEC : m);
    if ($urandom_range(0, 19) < 17) begin
      d = $urandom_range(1, month_length(mc, yc));
    end else begin
      d = $urandom_range(0, 31);
    end
    // Mostly short offsets keep the run short; a few span the full range.
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      mag = $urandom_range(0, 400);
    end else if (sel < 95) begin
      mag = $urandom_range(0, 3000);
    end else begin
      mag = $urandom_range(0, OFS_MAG_MAX);
    end
    if ($urandom_range(0, 1) == 1) begin
      ofs = -int'(mag);
    end else begin
      ofs = (mag > OFFSET_LIMIT) ? OFFSET_LIMIT : int'(mag);
    end
    send_paced(d, m, y, ofs);
  endtask

  initial begin
    sb = new;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_day = '0;
    in_month = '0;
    in_year = '0;
    day_offset = '0;
    out_stall = 1'b0;
    burst_left = 3;
    n_sent = 0;
    idle_cycles = 0;
    rx_phase = 0;
    rx_mode = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Year range limits in both directions.
    send_paced(1, 1, 0, -1);
    send_paced(31, 12, 9999, 1);
    send_paced(31, 12, 0, -65535);
    send_paced(1, 1, 9999, 65535);
    // Clamping of day, month and year.
    send_paced(0, 0, 0, 0);
    send_paced(31, 15, 16383, 0);
    send_paced(31, 13, 10000, -1);
    send_paced(31, 2, 2000, 0);
    send_paced(31, 4, 1999, 0);
    send_paced(0, 7, 1500, 3);
    // Leap rule around February, including year zero.
    send_paced(28, 2, 1900, 1);
    send_paced(28, 2, 2000, 1);
    send_paced(1, 3, 2004, -1);
    send_paced(1, 3, 2100, -1);
    send_paced(1, 3, 0, -1);
    send_paced(31, 12, 1999, 1);
    send_paced(1, 1, 2000, -1);
    send_paced(15, 8, 1234, 0);
    // Offset extremes: the most negative code moves the limit backward.
    send_paced(1, 1, 2000, 65535);
    send_paced(1, 1, 5000, -65536);
    send_paced(29, 2, 2400, -65535);

    for (int i = 0; i < RANDOM_DATES; i++) begin
      send_random_date();
    end
    idle_input(1);

    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d start dates and checked %0d result words.", n_sent, sb.n_checked);
    $display("%0d results saturated at a year range limit; %0d mismatches.",
             sb.n_saturated, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cdo_pkg.sv
sv/cdo_step.sv
sv/calendar_date_offset_unit.sv
tb/sv/tb_calendar_date_offset_unit.sv
